// ----- design/dbpmt_pkg.sv -----
`default_nettype none

package dbpmt_pkg;

    // Sequencer states of the tracker.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_SUM,
        ST_ROOT,
        ST_FINISH
    } t_state;

    // The four distances worked out for one sample, in the order they are computed.
    typedef enum logic [1:0] {
        DIST_ABS,
        DIST_CUR,
        DIST_PREV,
        DIST_REF
    } t_dist;

    // Control that travels alongside each operand pair into the square-and-add unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_sq_ctl;

    localparam int unsigned AXES       = 3;
    localparam int unsigned DB_W       = 12;
    localparam int unsigned MASK_W     = 9;
    localparam int unsigned DIST_OUT_W = 25;
    localparam int unsigned REL_OUT_W  = 26;
    localparam int unsigned AXIS_OUT_W = 25;

    // Relatch mask bit positions.
    localparam int unsigned MB_ABS   = 0;
    localparam int unsigned MB_REL   = 1;
    localparam int unsigned MB_YSTEP = 2;
    localparam int unsigned MB_XSTEP = 3;
    localparam int unsigned MB_ZSTEP = 4;
    localparam int unsigned MB_DIST  = 5;
    localparam int unsigned MB_XOFF  = 6;
    localparam int unsigned MB_YOFF  = 7;
    localparam int unsigned MB_ZOFF  = 8;

endpackage

`default_nettype wire

// ----- design/dbpmt_sqacc.sv -----
`default_nettype none

// Squares the difference of one coordinate pair per cycle and sums first to last pair.
module dbpmt_sqacc
    import dbpmt_pkg::*;
#(
    parameter int unsigned COORD_BITS = 24,
    localparam int unsigned SUM_W = 2 * COORD_BITS + 2,
    localparam int unsigned RAD_W = (SUM_W > 64) ? 64 : SUM_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_sq_ctl                      i_ctl,
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    output logic                         o_done,
    output logic [RAD_W-1:0]             o_sum
);

    logic signed [COORD_BITS:0]  diff;
    logic        [COORD_BITS:0]  mag_full;
    logic        [COORD_BITS-1:0] r_mag;
    logic        [2*COORD_BITS-1:0] r_sq;
    logic        [SUM_W-1:0]     r_acc;
    t_sq_ctl                     r_ctl1;
    t_sq_ctl                     r_ctl2;
    logic                        r_done;

    assign diff     = $signed({i_a[COORD_BITS-1], i_a}) - $signed({i_b[COORD_BITS-1], i_b});
    assign mag_full = diff[COORD_BITS] ? -diff : diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_done <= r_ctl2.valid && r_ctl2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_mag <= mag_full[COORD_BITS-1:0];
        end
        if (r_ctl1.valid) begin
            r_sq <= r_mag * r_mag;
        end
        if (r_ctl2.valid) begin
            if (r_ctl2.first) begin
                r_acc <= SUM_W'(r_sq);
            end else begin
                r_acc <= r_acc + SUM_W'(r_sq);
            end
        end
    end

    // A sum wider than 64 bits saturates to 64 bits before the root is taken.
    generate
        if (SUM_W > RAD_W) begin : g_sat
            assign o_sum = (|r_acc[SUM_W-1:RAD_W]) ? '1 : r_acc[RAD_W-1:0];
        end else begin : g_nosat
            assign o_sum = r_acc;
        end
    endgenerate

    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- design/dbpmt_isqrt.sv -----
`default_nettype none

// Floor integer square root, one result bit per cycle.
module dbpmt_isqrt
    import dbpmt_pkg::*;
#(
    parameter int unsigned RAD_W = 50,
    localparam int unsigned ROOT_W = RAD_W / 2,
    localparam int unsigned CNT_W = $clog2(ROOT_W + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W+3:0] shifted;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] rem_sub;
    logic              fits;

    assign shifted = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial   = (ROOT_W + 4)'({r_root, 2'b01});
    assign fits    = shifted >= trial;
    assign rem_sub = fits ? (shifted - trial) : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= rem_sub[ROOT_W+1:0];
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ----- design/deadband_position_motion_tracker.sv -----
// Dead-band position motion tracker.
// Items enter on the input channel (i_in_valid / o_in_ready) and results leave on the
// output channel (o_out_valid / i_out_ready); both are plain valid/ready handshakes.
// A sample item (req_type 0) yields one result of nine motion figures. A relatch item
// (req_type 1) yields no result: it is taken while the block is idle and loads the
// references chosen by its mask, so relatch items may follow one another back to back.
// A sample works out four Euclidean distances one after the other on a single
// square-and-add unit and a single bit-serial root unit. For each distance the three
// operand pairs are fed, the square pipeline drains and the root unit then works out
// ROOT_W result bits, where ROOT_W = COORD_BITS + 1 (32 at most). After the fourth
// distance the result register is loaded, and the block is ready for the next item in
// the cycle after that. o_in_ready is low for the whole of a sample.
// The result register lets a new item be accepted while an earlier result waits; if the
// receiver still holds off when the next result is ready, the block waits in its final
// step with the result computed but not yet committed.
// The dead band is written through i_cfg_wr_en / i_cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Reset clears all reference and previous points and sets the dead band to about 0.01
// in the coordinate format (41 for twelve fraction bits).
`default_nettype none

module deadband_position_motion_tracker
    import dbpmt_pkg::*;
#(
    parameter int unsigned COORD_BITS = 24,
    parameter int unsigned FRAC_BITS  = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [DB_W-1:0]              i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_req_type,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic [MASK_W-1:0]            i_relatch_mask,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [DIST_OUT_W-1:0]        o_abs_velocity,
    output logic signed [REL_OUT_W-1:0]  o_rel_velocity,
    output logic signed [AXIS_OUT_W-1:0] o_step_x,
    output logic signed [AXIS_OUT_W-1:0] o_step_y,
    output logic signed [AXIS_OUT_W-1:0] o_step_z,
    output logic [DIST_OUT_W-1:0]        o_ref_distance,
    output logic signed [AXIS_OUT_W-1:0] o_offset_x,
    output logic signed [AXIS_OUT_W-1:0] o_offset_y,
    output logic signed [AXIS_OUT_W-1:0] o_offset_z
);

    localparam int unsigned SUM_W  = 2 * COORD_BITS + 2;
    localparam int unsigned RAD_W  = (SUM_W > 64) ? 64 : SUM_W;
    localparam int unsigned ROOT_W = RAD_W / 2;
    localparam int unsigned DB_RESET_FULL = ((32'd1 << FRAC_BITS) + 32'd50) / 32'd100;
    localparam logic [DB_W-1:0] DB_RESET  = DB_W'(DB_RESET_FULL);
    localparam logic [1:0]      AXIS_LAST = 2'd2;

    t_state r_state;
    t_state n_state;
    t_dist  r_didx;
    logic [1:0] r_axis;

    logic [DB_W-1:0] r_deadband;

    logic signed [COORD_BITS-1:0] in_pos [AXES];
    logic signed [COORD_BITS-1:0] r_pos [AXES];
    logic signed [COORD_BITS-1:0] r_abs_prev [AXES];
    logic signed [COORD_BITS-1:0] r_rel_ref [AXES];
    logic signed [COORD_BITS-1:0] r_rel_prev [AXES];
    logic signed [COORD_BITS-1:0] r_axis_prev [AXES];
    logic signed [COORD_BITS-1:0] r_dist_ref [AXES];
    logic signed [COORD_BITS-1:0] r_axis_ref [AXES];

    logic [ROOT_W-1:0] r_dist [4];

    logic                         r_out_valid;
    logic [DIST_OUT_W-1:0]        r_abs_velocity;
    logic signed [REL_OUT_W-1:0]  r_rel_velocity;
    logic signed [AXIS_OUT_W-1:0] r_step [AXES];
    logic [DIST_OUT_W-1:0]        r_ref_distance;
    logic signed [AXIS_OUT_W-1:0] r_offset [AXES];

    t_sq_ctl sq_ctl;
    logic signed [COORD_BITS-1:0] op_a;
    logic signed [COORD_BITS-1:0] op_b;
    logic                 sum_done;
    logic [RAD_W-1:0]     sq_sum;
    logic                 root_start;
    logic                 root_done;
    logic [ROOT_W-1:0]    root_val;
    logic                 fin_go;
    logic                 in_ready;
    logic                 in_accept;

    logic                         abs_move;
    logic signed [ROOT_W:0]       rel_diff;
    logic [ROOT_W:0]              rel_mag;
    logic                         rel_move;
    logic signed [COORD_BITS:0]   step_d [AXES];
    logic [COORD_BITS:0]          step_mag [AXES];
    logic                         step_move [AXES];
    logic signed [COORD_BITS:0]   off_d [AXES];

    assign in_pos[0] = i_pos_x;
    assign in_pos[1] = i_pos_y;
    assign in_pos[2] = i_pos_z;

    assign in_accept  = i_in_valid && in_ready;
    assign o_in_ready = in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_req_type) begin
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                if (r_axis == AXIS_LAST) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum_done) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    n_state = (r_didx == DIST_REF) ? ST_FINISH : ST_FEED;
                end
            end
            ST_FINISH: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        sq_ctl     = '0;
        root_start = 1'b0;
        fin_go     = 1'b0;
        in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_FEED: begin
                sq_ctl.valid = 1'b1;
                sq_ctl.first = (r_axis == 2'd0);
                sq_ctl.last  = (r_axis == AXIS_LAST);
            end
            ST_SUM: begin
                root_start = sum_done;
            end
            ST_ROOT: begin
            end
            ST_FINISH: begin
                fin_go = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    // The previous-radius distance measures the held point, all others the sample.
    always_comb begin
        op_a = (r_didx == DIST_PREV) ? r_rel_prev[r_axis] : r_pos[r_axis];
        unique case (r_didx)
            DIST_ABS:            op_b = r_abs_prev[r_axis];
            DIST_CUR, DIST_PREV: op_b = r_rel_ref[r_axis];
            DIST_REF:            op_b = r_dist_ref[r_axis];
        endcase
    end

    dbpmt_sqacc #(
        .COORD_BITS (COORD_BITS)
    ) u_sqacc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq_ctl),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (sum_done),
        .o_sum   (sq_sum)
    );

    dbpmt_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (sq_sum),
        .o_done     (root_done),
        .o_root     (root_val)
    );

    // Dead-band decisions once all four distances are known. Every compare is strict.
    always_comb begin
        abs_move = {1'b0, r_dist[DIST_ABS]} > (ROOT_W + 1)'(r_deadband);
        rel_diff = $signed({1'b0, r_dist[DIST_CUR]}) - $signed({1'b0, r_dist[DIST_PREV]});
        rel_mag  = rel_diff[ROOT_W] ? -rel_diff : rel_diff;
        rel_move = rel_mag > (ROOT_W + 1)'(r_deadband);
        for (int i = 0; i < AXES; i++) begin
            step_d[i]    = $signed({r_pos[i][COORD_BITS-1], r_pos[i]})
                         - $signed({r_axis_prev[i][COORD_BITS-1], r_axis_prev[i]});
            step_mag[i]  = step_d[i][COORD_BITS] ? -step_d[i] : step_d[i];
            step_move[i] = step_mag[i] > (COORD_BITS + 1)'(r_deadband);
            off_d[i]     = $signed({r_pos[i][COORD_BITS-1], r_pos[i]})
                         - $signed({r_axis_ref[i][COORD_BITS-1], r_axis_ref[i]});
        end
    end

    // Control and tracked state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_didx      <= DIST_ABS;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
            r_deadband  <= DB_RESET;
            for (int i = 0; i < AXES; i++) begin
                r_abs_prev[i]  <= '0;
                r_rel_ref[i]   <= '0;
                r_rel_prev[i]  <= '0;
                r_axis_prev[i] <= '0;
                r_dist_ref[i]  <= '0;
                r_axis_ref[i]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                r_deadband <= i_cfg_wr_data;
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end

            if (in_accept) begin
                r_didx <= DIST_ABS;
                r_axis <= '0;
            end
            if (in_accept && i_req_type) begin
                if (i_relatch_mask[MB_ABS]) begin
                    r_abs_prev <= in_pos;
                end
                if (i_relatch_mask[MB_REL]) begin
                    r_rel_ref  <= in_pos;
                    r_rel_prev <= in_pos;
                end
                if (i_relatch_mask[MB_XSTEP]) begin
                    r_axis_prev[0] <= in_pos[0];
                end
                if (i_relatch_mask[MB_YSTEP]) begin
                    r_axis_prev[1] <= in_pos[1];
                end
                if (i_relatch_mask[MB_ZSTEP]) begin
                    r_axis_prev[2] <= in_pos[2];
                end
                if (i_relatch_mask[MB_DIST]) begin
                    r_dist_ref <= in_pos;
                end
                if (i_relatch_mask[MB_XOFF]) begin
                    r_axis_ref[0] <= in_pos[0];
                end
                if (i_relatch_mask[MB_YOFF]) begin
                    r_axis_ref[1] <= in_pos[1];
                end
                if (i_relatch_mask[MB_ZOFF]) begin
                    r_axis_ref[2] <= in_pos[2];
                end
            end

            if (r_state == ST_FEED) begin
                r_axis <= (r_axis == AXIS_LAST) ? 2'd0 : r_axis + 2'd1;
            end
            if (r_state == ST_ROOT && root_done) begin
                r_didx <= t_dist'(r_didx + 2'd1);
            end

            if (fin_go) begin
                if (abs_move) begin
                    r_abs_prev <= r_pos;
                end
                if (rel_move) begin
                    r_rel_prev <= r_pos;
                end
                for (int i = 0; i < AXES; i++) begin
                    if (step_move[i]) begin
                        r_axis_prev[i] <= r_pos[i];
                    end
                end
            end
        end
    end

    // Sample, distances and result register.
    always_ff @(posedge i_clk) begin
        if (in_accept && !i_req_type) begin
            r_pos <= in_pos;
        end
        if (r_state == ST_ROOT && root_done) begin
            r_dist[r_didx] <= root_val;
        end
        if (fin_go) begin
            r_abs_velocity <= abs_move ? DIST_OUT_W'(r_dist[DIST_ABS]) : '0;
            r_rel_velocity <= rel_move ? REL_OUT_W'(rel_diff) : '0;
            r_ref_distance <= DIST_OUT_W'(r_dist[DIST_REF]);
            for (int i = 0; i < AXES; i++) begin
                r_step[i]   <= step_move[i] ? AXIS_OUT_W'(step_d[i]) : '0;
                r_offset[i] <= AXIS_OUT_W'(off_d[i]);
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_abs_velocity = r_abs_velocity;
    assign o_rel_velocity = r_rel_velocity;
    assign o_step_x       = r_step[0];
    assign o_step_y       = r_step[1];
    assign o_step_z       = r_step[2];
    assign o_ref_distance = r_ref_distance;
    assign o_offset_x     = r_offset[0];
    assign o_offset_y     = r_offset[1];
    assign o_offset_z     = r_offset[2];

    a_sum_only_when_waited: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        sum_done |-> r_state == ST_SUM
    ) else $error("square sum completed outside the summing step");

    a_root_only_when_waited: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        root_done |-> r_state == ST_ROOT
    ) else $error("root completed outside the root step");

    a_last_root_finishes: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT && root_done && r_didx == DIST_REF) |=> r_state == ST_FINISH
    ) else $error("final distance did not lead to the finishing step");

    a_finish_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (r_out_valid && r_state == ST_IDLE)
    ) else $error("finished sample did not present a result");

endmodule

`default_nettype wire

// ----- verif/motion_tb_pkg.sv -----
`timescale 1ns / 1ps

package motion_tb_pkg;

    // Kinds of input item.
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_RELATCH = 1'b1;

endpackage

// ----- verif/motion_figure_checker.sv -----
`timescale 1ns / 1ps

module motion_figure_checker
    import dbpmt_pkg::*;
    import motion_tb_pkg::*;
#(
    parameter int unsigned COORD_BITS = 24,
    parameter int unsigned FRAC_BITS  = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [DB_W-1:0]              i_cfg_wr_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_req_type,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic [MASK_W-1:0]            i_relatch_mask,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [DIST_OUT_W-1:0]        i_abs_velocity,
    input  logic signed [REL_OUT_W-1:0]  i_rel_velocity,
    input  logic signed [AXIS_OUT_W-1:0] i_step_x,
    input  logic signed [AXIS_OUT_W-1:0] i_step_y,
    input  logic signed [AXIS_OUT_W-1:0] i_step_z,
    input  logic [DIST_OUT_W-1:0]        i_ref_distance,
    input  logic signed [AXIS_OUT_W-1:0] i_offset_x,
    input  logic signed [AXIS_OUT_W-1:0] i_offset_y,
    input  logic signed [AXIS_OUT_W-1:0] i_offset_z,
    output int                           o_pending,
    output int                           o_mismatches
);

    localparam logic [DB_W-1:0] BAND_AT_RESET = DB_W'(((1 << FRAC_BITS) + 50) / 100);

    // Index 0 is X, 1 is Y and 2 is Z.
    typedef logic [AXES-1:0][COORD_BITS-1:0] point_t;

    typedef struct packed {
        logic [DIST_OUT_W-1:0]        abs_velocity;
        logic signed [REL_OUT_W-1:0]  rel_velocity;
        logic signed [AXIS_OUT_W-1:0] step_x;
        logic signed [AXIS_OUT_W-1:0] step_y;
        logic signed [AXIS_OUT_W-1:0] step_z;
        logic [DIST_OUT_W-1:0]        ref_distance;
        logic signed [AXIS_OUT_W-1:0] offset_x;
        logic signed [AXIS_OUT_W-1:0] offset_y;
        logic signed [AXIS_OUT_W-1:0] offset_z;
    } figures_t;

    point_t          abs_prev, rel_ref, rel_prev, axis_prev, dist_ref, axis_ref;
    logic [DB_W-1:0] band;
    figures_t        awaited_figures [$];
    int              pending_count  = 0;
    int              mismatch_count = 0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic compare_figure(input string name, input logic signed [REL_OUT_W-1:0] seen,
                                  input logic signed [REL_OUT_W-1:0] wanted);
        if (seen !== wanted)
            report_mismatch($sformatf("%s is %0d, predicted %0d", name, seen, wanted));
    endtask

    // Floor square root, settled two bits at a time.
    function automatic longint unsigned floor_root(input longint unsigned value);
        longint unsigned rest, root, probe;
        rest  = value;
        root  = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rest)
            probe >>= 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Euclidean distance between two points; the sum of squares saturates.
    function automatic longint unsigned span(input point_t a, input point_t b);
        longint unsigned total, square;
        longint          diff;
        int              i;
        total = 0;
        for (i = 0; i < AXES; i++) begin
            diff = longint'($signed(a[i])) - longint'($signed(b[i]));
            if (diff < 0)
                diff = -diff;
            square = longint'(diff) * longint'(diff);
            total  = (total > 64'hFFFF_FFFF_FFFF_FFFF - square) ? '1 : total + square;
        end
        return floor_root(total);
    endfunction

    always @(posedge i_clk) begin : watch
        point_t   here;
        figures_t wanted;
        longint   limit, travel, radius_now, radius_was, radial, diff;
        longint   stride [AXES];
        longint   offset [AXES];
        int       a;
        if (!i_rst_n) begin
            abs_prev  = '0;
            rel_ref   = '0;
            rel_prev  = '0;
            axis_prev = '0;
            dist_ref  = '0;
            axis_ref  = '0;
            band      = BAND_AT_RESET;
            awaited_figures.delete();
        end else begin
            if (i_cfg_wr_en)
                band = i_cfg_wr_data;

            // Results are checked before the new item is predicted, so that a result
            // leaving at the same edge is matched against an older sample.
            if (i_out_valid && i_out_ready) begin
                if (awaited_figures.size() == 0) begin
                    report_mismatch("result arrived with no sample outstanding");
                end else begin
                    wanted = awaited_figures.pop_front();
                    compare_figure("abs_velocity", i_abs_velocity, wanted.abs_velocity);
                    compare_figure("rel_velocity", i_rel_velocity, wanted.rel_velocity);
                    compare_figure("step_x", i_step_x, wanted.step_x);
                    compare_figure("step_y", i_step_y, wanted.step_y);
                    compare_figure("step_z", i_step_z, wanted.step_z);
                    compare_figure("ref_distance", i_ref_distance, wanted.ref_distance);
                    compare_figure("offset_x", i_offset_x, wanted.offset_x);
                    compare_figure("offset_y", i_offset_y, wanted.offset_y);
                    compare_figure("offset_z", i_offset_z, wanted.offset_z);
                end
            end

            if (i_in_valid && i_in_ready) begin
                here[0] = i_pos_x;
                here[1] = i_pos_y;
                here[2] = i_pos_z;
                if (i_req_type == REQ_RELATCH) begin
                    if (i_relatch_mask[MB_ABS])
                        abs_prev = here;
                    if (i_relatch_mask[MB_REL]) begin
                        rel_ref  = here;
                        rel_prev = here;
                    end
                    if (i_relatch_mask[MB_XSTEP])
                        axis_prev[0] = here[0];
                    if (i_relatch_mask[MB_YSTEP])
                        axis_prev[1] = here[1];
                    if (i_relatch_mask[MB_ZSTEP])
                        axis_prev[2] = here[2];
                    if (i_relatch_mask[MB_DIST])
                        dist_ref = here;
                    if (i_relatch_mask[MB_XOFF])
                        axis_ref[0] = here[0];
                    if (i_relatch_mask[MB_YOFF])
                        axis_ref[1] = here[1];
                    if (i_relatch_mask[MB_ZOFF])
                        axis_ref[2] = here[2];
                end else begin
                    limit = longint'(band);

                    travel = longint'(span(here, abs_prev));
                    if (travel > limit)
                        abs_prev = here;
                    else
                        travel = 0;

                    radius_now = longint'(span(here, rel_ref));
                    radius_was = longint'(span(rel_prev, rel_ref));
                    radial     = radius_now - radius_was;
                    if ((radial < 0 ? -radial : radial) > limit)
                        rel_prev = here;
                    else
                        radial = 0;

                    for (a = 0; a < AXES; a++) begin
                        diff = longint'($signed(here[a])) - longint'($signed(axis_prev[a]));
                        if ((diff < 0 ? -diff : diff) > limit) begin
                            stride[a]    = diff;
                            axis_prev[a] = here[a];
                        end else begin
                            stride[a] = 0;
                        end
                        offset[a] = longint'($signed(here[a])) - longint'($signed(axis_ref[a]));
                    end

                    wanted.abs_velocity = DIST_OUT_W'(travel);
                    wanted.rel_velocity = REL_OUT_W'(radial);
                    wanted.step_x       = AXIS_OUT_W'(stride[0]);
                    wanted.step_y       = AXIS_OUT_W'(stride[1]);
                    wanted.step_z       = AXIS_OUT_W'(stride[2]);
                    wanted.ref_distance = DIST_OUT_W'(span(here, dist_ref));
                    wanted.offset_x     = AXIS_OUT_W'(offset[0]);
                    wanted.offset_y     = AXIS_OUT_W'(offset[1]);
                    wanted.offset_z     = AXIS_OUT_W'(offset[2]);
                    awaited_figures.push_back(wanted);
                end
            end
        end
        pending_count <= awaited_figures.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import dbpmt_pkg::*;
    import motion_tb_pkg::*;

    localparam int unsigned COORD_BITS = 24;
    localparam int unsigned FRAC_BITS  = 12;

    // A sample keeps the block busy for less time than this wait, so waiting this long
    // is enough for any item in flight to have left the block.
    localparam int BLOCK_LATENCY = 150;

    // Items per random phase; six phases make up the random part of the run.
    localparam int PHASE_ITEMS = 210;
    localparam int PHASES      = 6;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam int     BAND_TOP  = (1 << DB_W) - 1;

    logic                         clk;
    logic                         rst_n        = 1'b0;
    logic                         cfg_wr_en    = 1'b0;
    logic [DB_W-1:0]              cfg_wr_data  = '0;
    logic                         in_valid     = 1'b0;
    logic                         in_ready;
    logic                         req_type     = REQ_SAMPLE;
    coord_t                       pos_x        = '0;
    coord_t                       pos_y        = '0;
    coord_t                       pos_z        = '0;
    logic [MASK_W-1:0]            relatch_mask = '0;
    logic                         out_valid;
    logic                         out_ready    = 1'b0;
    logic [DIST_OUT_W-1:0]        abs_velocity;
    logic signed [REL_OUT_W-1:0]  rel_velocity;
    logic signed [AXIS_OUT_W-1:0] step_x, step_y, step_z;
    logic [DIST_OUT_W-1:0]        ref_distance;
    logic signed [AXIS_OUT_W-1:0] offset_x, offset_y, offset_z;

    int pending;
    int mismatches;

    // When calm is set neither side idles any more; gap_pct is the chance, in percent,
    // that the sender leaves a gap before an item.
    bit calm    = 1'b0;
    int gap_pct = 0;

    // The dead band currently programmed, used to aim random moves at the threshold.
    int band_now = ((1 << FRAC_BITS) + 50) / 100;

    // A point that wanders in small steps, so that successive samples sit close to the
    // latched points and the dead band actually decides the outcome.
    coord_t walk [AXES];

    deadband_position_motion_tracker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_pos_z        (pos_z),
        .i_relatch_mask (relatch_mask),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_abs_velocity (abs_velocity),
        .o_rel_velocity (rel_velocity),
        .o_step_x       (step_x),
        .o_step_y       (step_y),
        .o_step_z       (step_z),
        .o_ref_distance (ref_distance),
        .o_offset_x     (offset_x),
        .o_offset_y     (offset_y),
        .o_offset_z     (offset_z)
    );

    motion_figure_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_pos_z        (pos_z),
        .i_relatch_mask (relatch_mask),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_abs_velocity (abs_velocity),
        .i_rel_velocity (rel_velocity),
        .i_step_x       (step_x),
        .i_step_y       (step_y),
        .i_step_z       (step_z),
        .i_ref_distance (ref_distance),
        .i_offset_x     (offset_x),
        .i_offset_y     (offset_y),
        .i_offset_z     (offset_z),
        .o_pending      (pending),
        .o_mismatches   (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Backstop in case the block hangs. The slowest correct run takes far less time than
    // this timeout, which leaves a wide margin.
    initial begin
        #12_000_000;
        $display("Mismatches found");
        $finish;
    end

    // The receiver holds ready high for runs of varying length, now and then a long one,
    // and drops it for a random burst after each run until the calm part of the run.
    initial begin : receiver
        int burst;
        forever begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                : $urandom_range(1, 20);
            repeat (burst) begin
                @(negedge clk);
                out_ready <= 1'b1;
            end
            if (!calm) begin
                burst = $urandom_range(1, 10);
                repeat (burst) begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // Presents one item at a falling edge, after an optional gap, and holds it until the
    // block takes it at a rising edge. Valid is only ever assigned once per falling edge.
    task automatic send_item(input logic kind, input coord_t x, input coord_t y,
                             input coord_t z, input logic [MASK_W-1:0] mask);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        pos_x        <= x;
        pos_y        <= y;
        pos_z        <= z;
        relatch_mask <= mask;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Withdraws the sender, waits until every predicted result has been taken, and then
    // lets the block run on long enough to finish anything that produces no result.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (BLOCK_LATENCY) @(negedge clk);
    endtask

    // A random move along one axis, aimed mostly at the neighbourhood of the dead band,
    // with the exact threshold and the first value beyond it picked out now and then.
    function automatic int nudge(input int limit);
        case ($urandom_range(0, 9))
            0:       return limit;
            1:       return -limit;
            2:       return limit + 1;
            3:       return -limit - 1;
            default: return int'($urandom_range(0, 4 * limit + 16)) - (2 * limit + 8);
        endcase
    endfunction

    initial begin : stimulus
        int                phase, n, a, roll;
        logic [MASK_W-1:0] mask;
        coord_t            spot [AXES];

        for (a = 0; a < AXES; a++)
            walk[a] = '0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the dead band at its reset value.
        gap_pct = 20;
        // Everything at the origin: every figure is zero.
        send_item(REQ_SAMPLE, '0, '0, '0, '0);
        // Coordinate extremes; the mask of a sample is ignored.
        send_item(REQ_SAMPLE, COORD_MAX, COORD_MAX, COORD_MAX, '1);
        send_item(REQ_SAMPLE, COORD_MIN, COORD_MIN, COORD_MIN, '0);
        send_item(REQ_SAMPLE, COORD_MAX, COORD_MIN, '0, '0);
        // Latch everything at the negative corner, then jump to the positive one for the
        // largest steps, offsets and distances the format allows.
        send_item(REQ_RELATCH, COORD_MIN, COORD_MIN, COORD_MIN, '1);
        send_item(REQ_SAMPLE, COORD_MAX, COORD_MAX, COORD_MAX, '0);
        // An empty mask must leave every reference alone.
        send_item(REQ_RELATCH, '0, '0, '0, '0);
        send_item(REQ_RELATCH, '0, '0, '0, '1);
        // A move exactly as large as the dead band is suppressed; one step further is not.
        send_item(REQ_SAMPLE, coord_t'(band_now), '0, '0, '0);
        send_item(REQ_SAMPLE, coord_t'(band_now + 1), coord_t'(-(band_now + 1)), '0, '0);
        send_item(REQ_SAMPLE, coord_t'(band_now + 1), coord_t'(-(band_now + 1)),
                  coord_t'(band_now), '0);
        // Each relatch bit on its own, at a distinct position, then one sample to see them.
        for (a = 0; a < MASK_W; a++)
            send_item(REQ_RELATCH, coord_t'(a * 1000 + 5), coord_t'(-a * 777),
                      coord_t'(a * 3), MASK_W'(1) << a);
        send_item(REQ_SAMPLE, coord_t'(-300), coord_t'(20), coord_t'(4000), '0);

        // Random part: each phase programs a new dead band while the block is idle,
        // the extremes among them, and the last phase runs without any idling.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0:       band_now = 0;
                1:       band_now = BAND_TOP;
                2:       band_now = $urandom_range(1, 100);
                3:       band_now = $urandom_range(0, BAND_TOP);
                4:       band_now = 1;
                default: band_now = ((1 << FRAC_BITS) + 50) / 100;
            endcase
            case (phase)
                0:       gap_pct = 25;
                1:       gap_pct = 40;
                2:       gap_pct = 0;
                3:       gap_pct = 25;
                4:       gap_pct = 10;
                default: gap_pct = 0;
            endcase
            calm = (phase == PHASES - 1);
            @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= DB_W'(band_now);
            @(negedge clk);
            cfg_wr_en   <= 1'b0;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through the second phase the sender stops until the block has
                // handed over every result it owes.
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    settle();
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    case ($urandom_range(0, 3))
                        0:       mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
                        1:       mask = '1;
                        default: mask = MASK_W'($urandom);
                    endcase
                    // Mostly relatch at the wandering point, sometimes anywhere at all.
                    for (a = 0; a < AXES; a++)
                        spot[a] = ($urandom_range(0, 4) == 0) ? coord_t'($urandom) : walk[a];
                    send_item(REQ_RELATCH, spot[0], spot[1], spot[2], mask);
                end else begin
                    for (a = 0; a < AXES; a++) begin
                        if (roll < 22)
                            walk[a] = coord_t'($urandom);
                        else
                            walk[a] = walk[a] + coord_t'(nudge(band_now));
                    end
                    send_item(REQ_SAMPLE, walk[0], walk[1], walk[2], MASK_W'($urandom));
                end
            end
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
